// ----- rtl/rsamx_pkg.sv -----
// ----------------------------------------------------------------------------
// rsamx_pkg
// Shared widths, register indexes and types for the block modular
// exponentiation core.
// ----------------------------------------------------------------------------
package rsamx_pkg;

  localparam int MODULUS_BITS = 27;
  localparam int CHAR_W       = 7;
  localparam int NUM_CHARS    = 3;
  localparam int PACK_W       = NUM_CHARS * CHAR_W;
  localparam int CNT_W        = $clog2(MODULUS_BITS);
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT     = 2'd3;

  typedef logic [MODULUS_BITS-1:0] word_t;
  typedef logic [CHAR_W-1:0]       char_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

// ----- rtl/rsamx_modmul.sv -----
// ----------------------------------------------------------------------------
// rsamx_modmul
// Bit-serial interleaved modular multiplier. The first operand is shifted
// out one bit per cycle, most significant bit first, and the partial result
// is doubled, added and reduced each cycle, so the result is (a * b) mod m.
// The second operand must be below the modulus; the first may be any value.
// ----------------------------------------------------------------------------
module rsamx_modmul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rsamx_pkg::word_t    op_a,
  input  rsamx_pkg::word_t    op_b,
  input  rsamx_pkg::word_t    op_m,
  output rsamx_pkg::word_t    result,
  output rsamx_pkg::mm_stat_t stat
);
  import rsamx_pkg::*;

  localparam int T_W = MODULUS_BITS + 2;

  word_t            a_r;
  word_t            b_r;
  word_t            m_r;
  word_t            acc_r;
  word_t            acc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [T_W-1:0] sum;
  logic [T_W-1:0] m1;
  logic [T_W-1:0] m2;

  always_comb begin
    m1  = T_W'(m_r);
    m2  = {1'b0, m_r, 1'b0};
    sum = {1'b0, acc_r, 1'b0} + (a_r[MODULUS_BITS-1] ? T_W'(b_r) : '0);
    if (sum >= m2) begin
      acc_nxt = MODULUS_BITS'(sum - m2);
    end else if (sum >= m1) begin
      acc_nxt = MODULUS_BITS'(sum - m1);
    end else begin
      acc_nxt = MODULUS_BITS'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        a_r    <= op_a;
        b_r    <= op_b;
        m_r    <= op_m;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        a_r   <= {a_r[MODULUS_BITS-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MODULUS_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign result    = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- rtl/rsa_block_modexp_core.sv -----
// ----------------------------------------------------------------------------
// rsa_block_modexp_core
// Textbook RSA on one block per beat with right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// Each input beat gives one output beat. All modular products run on one
// bit-serial multiplier. A block takes one product to reduce the base, one
// squaring per exponent bit and one extra multiply per set exponent bit. Each
// exponent bit also passes through an issue state, and the result is handed
// off in the done state before the next beat is taken. A modulus below 2
// skips the multiplier and gives a result of 0. One block is processed at a
// time; a new block is taken while the previous result still waits in the
// output register.
// ----------------------------------------------------------------------------
module rsa_block_modexp_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // cfg port
  input  logic                               cfg_we,
  input  logic [rsamx_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  rsamx_pkg::word_t                   cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: text_char0, text_char1, text_char2, cipher_in.
  input  logic [47:0]                        in_tdata,
  input  logic                               in_tlast,
  // output stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // Fields from bit 0: cipher_out, text_out0, text_out1, text_out2.
  output logic [47:0]                        out_tdata,
  output logic                               out_tlast
);
  import rsamx_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_BIT,
    ST_MULT,
    ST_SQR,
    ST_DONE
  } state_t;

  state_t           state_r;
  word_t            exponent_r;
  word_t            modulus_r;
  logic [1:0]       block_bytes_r;
  logic             decrypt_r;

  word_t            exp_sh_r;
  word_t            base_r;
  word_t            acc_r;
  logic [1:0]       nb_r;
  logic             mode_r;
  logic             last_r;
  logic [CNT_W-1:0] bit_cnt_r;

  logic             mm_start_r;
  word_t            mm_a_r;
  word_t            mm_b_r;
  word_t            mm_res;
  mm_stat_t         mm_stat;

  logic             out_tvalid_r;
  logic [47:0]      out_tdata_r;
  logic             out_tlast_r;

  char_t            c0;
  char_t            c1;
  char_t            c2;
  logic [1:0]       nb_in;
  word_t            packed_in;
  word_t            base_in;
  logic [47:0]      out_data;

  rsamx_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mm_start_r),
    .op_a   (mm_a_r),
    .op_b   (mm_b_r),
    .op_m   (modulus_r),
    .result (mm_res),
    .stat   (mm_stat)
  );

  always_comb begin
    c0    = in_tdata[6:0];
    c1    = in_tdata[13:7];
    c2    = in_tdata[20:14];
    nb_in = (block_bytes_r == 2'd0) ? 2'd1 : block_bytes_r;
    case (nb_in)
      2'd3:    packed_in = MODULUS_BITS'({c2, c1, c0});
      2'd2:    packed_in = MODULUS_BITS'({c1, c0});
      default: packed_in = MODULUS_BITS'(c0);
    endcase
    base_in = decrypt_r ? in_tdata[47:21] : packed_in;
  end

  always_comb begin
    out_data = '0;
    if (!mode_r) begin
      out_data[26:0] = acc_r;
    end else begin
      out_data[33:27] = acc_r[6:0];
      if (nb_r >= 2'd2) begin
        out_data[40:34] = acc_r[13:7];
      end
      if (nb_r == 2'd3) begin
        out_data[47:41] = acc_r[20:14];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      exponent_r    <= MODULUS_BITS'(1);
      modulus_r     <= MODULUS_BITS'(2);
      block_bytes_r <= 2'd1;
      decrypt_r     <= 1'b0;
      mm_start_r    <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      mm_start_r <= 1'b0;
      if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_EXPONENT:    exponent_r    <= cfg_wdata;
          CFG_MODULUS:     modulus_r     <= cfg_wdata;
          CFG_BLOCK_BYTES: block_bytes_r <= cfg_wdata[1:0];
          CFG_DECRYPT:     decrypt_r     <= cfg_wdata[0];
          default:         ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            exp_sh_r  <= exponent_r;
            nb_r      <= nb_in;
            mode_r    <= decrypt_r;
            last_r    <= in_tlast;
            bit_cnt_r <= '0;
            if (modulus_r < MODULUS_BITS'(2)) begin
              acc_r   <= '0;
              state_r <= ST_DONE;
            end else begin
              mm_a_r     <= base_in;
              mm_b_r     <= MODULUS_BITS'(1);
              mm_start_r <= 1'b1;
              state_r    <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mm_stat.done) begin
            base_r  <= mm_res;
            acc_r   <= MODULUS_BITS'(1);
            state_r <= ST_BIT;
          end
        end
        ST_BIT: begin
          mm_start_r <= 1'b1;
          if (exp_sh_r[0]) begin
            mm_a_r  <= acc_r;
            mm_b_r  <= base_r;
            state_r <= ST_MULT;
          end else begin
            mm_a_r  <= base_r;
            mm_b_r  <= base_r;
            state_r <= ST_SQR;
          end
        end
        ST_MULT: begin
          if (mm_stat.done) begin
            acc_r      <= mm_res;
            mm_a_r     <= base_r;
            mm_b_r     <= base_r;
            mm_start_r <= 1'b1;
            state_r    <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (mm_stat.done) begin
            base_r    <= mm_res;
            exp_sh_r  <= {1'b0, exp_sh_r[MODULUS_BITS-1:1]};
            bit_cnt_r <= bit_cnt_r + 1'b1;
            if (bit_cnt_r == CNT_W'(MODULUS_BITS - 1)) begin
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_BIT;
            end
          end
        end
        ST_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= out_data;
            out_tlast_r  <= last_r;
            state_r      <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef SYNTH
  a_idle_mul_quiet : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mm_stat.busy)
    else $error("multiplier busy while the core is idle");

  a_product_reduced : assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SQR || state_r == ST_MULT || state_r == ST_REDUCE) && mm_stat.done)
      |-> mm_res < modulus_r)
    else $error("modular product not below the modulus");

  a_out_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_DONE))
    else $error("output beat raised outside the done state");
`endif

endmodule
